// ===== rtl/lzwd_pkg.sv =====
// Package for the LZSS window decoder: field widths, token decoding constants
// and the byte handoff struct. No dependencies.
package lzwd_pkg;

    localparam int WIN_DEPTH = 4096;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int BYTE_W    = 8;
    localparam int TOKEN_W   = 16;
    localparam int LEN_W     = 5;

    // Token layout: distance minus one in the low bits, length minus three above.
    localparam logic [LEN_W-1:0] MIN_MATCH = 5'd3;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [WIN_AW-1:0] t_waddr;
    typedef logic [LEN_W-1:0]  t_len;

    // One decoded byte waiting to be written to the window and the output register.
    typedef struct packed {
        logic  valid;
        t_byte data;
        logic  last;
    } t_byte_xfer;

endpackage

// ===== rtl/lzwd_in_if.sv =====
// Input channel of the LZSS window decoder: one token per transaction.
// Depends on nothing.
interface lzwd_in_if;
    logic        valid;
    logic        ready;
    logic        is_match;
    logic [7:0]  literal_byte;
    logic [15:0] match_token;

    modport source (output valid, output is_match, output literal_byte,
                    output match_token, input ready);
    modport sink   (input valid, input is_match, input literal_byte,
                    input match_token, output ready);
endinterface

// ===== rtl/lzwd_out_if.sv =====
// Output channel of the LZSS window decoder: one decoded byte per transaction.
// Depends on nothing.
interface lzwd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== rtl/lzss_window_decoder_unit.sv =====
// Channel   | Dir | Payload                                   | Per transaction
// i_in      | in  | is_match, literal_byte, match_token       | one LZSS token
// o_out     | out | out_byte, last                            | one decoded byte
//
// A literal's byte is staged in the pending slot and then moves into the output register; the
// bytes of a match of length L (3 to 18) follow it there in order, one byte per cycle while the
// sink does not stall, through the single read port of the 4096-byte window RAM. The next token
// is taken only after the last byte has moved into the output register.
// Reset clears the write pointer and handshake state; the window is not cleared.
// Output stalls hold the pending byte and pause further window reads.
// Top level of the LZSS window decoder. Depends on lzwd_pkg, the channel
// interfaces, lzwd_ram, lzwd_seq and lzwd_out.
module lzss_window_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lzwd_in_if.sink    i_in,
    lzwd_out_if.source o_out
);
    import lzwd_pkg::*;

    logic       we;
    t_waddr     waddr;
    t_byte      wdata;
    logic       re;
    t_waddr     raddr;
    t_byte      rd_data;
    t_byte_xfer pend_byte;
    logic       take;

    // History window.
    lzwd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WIN_DEPTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rd_data)
    );

    // Token decode and copy sequencing.
    lzwd_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_take    (take),
        .i_rd_data (rd_data),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_re      (re),
        .o_raddr   (raddr),
        .o_byte    (pend_byte)
    );

    // Output register toward the sink.
    lzwd_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (pend_byte),
        .o_take  (take),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/lzwd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered
// read data that holds while no read is enabled. No dependencies.
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; a read in the same cycle as a write to that entry sees old data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lzwd_seq.sv =====
// Copy sequencer of the LZSS window decoder: takes tokens, issues window
// reads, writes decoded bytes back. Depends on lzwd_pkg and lzwd_in_if.
module lzwd_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lzwd_in_if.sink              i_in,
    input  logic                 i_take,
    input  lzwd_pkg::t_byte      i_rd_data,
    output logic                 o_we,
    output lzwd_pkg::t_waddr     o_waddr,
    output lzwd_pkg::t_byte      o_wdata,
    output logic                 o_re,
    output lzwd_pkg::t_waddr     o_raddr,
    output lzwd_pkg::t_byte_xfer o_byte
);
    import lzwd_pkg::*;

    // Control state.
    logic   r_pend;
    t_len   r_rem;
    t_waddr r_wp;

    // Payload of the pending byte and the copy read pointer.
    t_waddr r_rd_ptr;
    logic   r_fwd;
    t_byte  r_fwd_byte;
    logic   r_pend_last;

    logic   accept;
    logic   consume;
    logic   issue;
    t_byte  cons_byte;
    t_len   match_len;
    t_waddr match_src;

    // Tokens are taken only when no copy is running and nothing is pending.
    assign i_in.ready = (r_rem == '0) && !r_pend;
    assign accept     = i_in.valid && i_in.ready;

    assign match_len = t_len'(i_in.match_token[15:12]) + MIN_MATCH;
    assign match_src = r_wp - t_waddr'(i_in.match_token[11:0]) - t_waddr'(1);

    // A pending byte leaves when the output register can take it.
    assign consume   = r_pend && i_take;
    assign cons_byte = r_fwd ? r_fwd_byte : i_rd_data;

    // Next copy read goes out when the pending slot is empty or frees up this cycle.
    assign issue = (r_rem != '0) && (!r_pend || consume);

    // Window port connections.
    assign o_we    = consume;
    assign o_waddr = r_wp;
    assign o_wdata = cons_byte;
    assign o_re    = issue;
    assign o_raddr = r_rd_ptr;

    assign o_byte.valid = r_pend;
    assign o_byte.data  = cons_byte;
    assign o_byte.last  = r_pend_last;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_rem  <= '0;
            r_wp   <= '0;
        end else begin
            if (consume) begin
                r_wp <= r_wp + t_waddr'(1);
            end
            if (accept && !i_in.is_match) begin
                r_pend <= 1'b1;
            end else if (issue) begin
                r_pend <= 1'b1;
            end else if (consume) begin
                r_pend <= 1'b0;
            end
            if (accept && i_in.is_match) begin
                r_rem <= match_len;
            end else if (issue) begin
                r_rem <= r_rem - t_len'(1);
            end
        end
    end

    // Payload registers. A read that hits the entry written in the same cycle
    // takes the written byte instead of the stale RAM data.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_in.is_match) begin
                r_rd_ptr <= match_src;
            end else begin
                r_fwd       <= 1'b1;
                r_fwd_byte  <= i_in.literal_byte;
                r_pend_last <= 1'b1;
            end
        end else if (issue) begin
            r_rd_ptr    <= r_rd_ptr + t_waddr'(1);
            r_fwd       <= consume && (r_rd_ptr == r_wp);
            r_fwd_byte  <= cons_byte;
            r_pend_last <= (r_rem == t_len'(1));
        end
    end

endmodule

// ===== rtl/lzwd_out.sv =====
// Output register of the LZSS window decoder: holds one byte for the sink.
// Depends on lzwd_pkg and lzwd_out_if.
module lzwd_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lzwd_pkg::t_byte_xfer i_byte,
    output logic                 o_take,
    lzwd_out_if.source           o_out
);
    import lzwd_pkg::*;

    logic  r_valid;
    t_byte r_data;
    logic  r_last;

    // The register is free when empty or when its transaction completes now.
    assign o_take = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_byte.valid) begin
            r_data <= i_byte.data;
            r_last <= i_byte.last;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_data;
    assign o_out.last     = r_last;

endmodule

// ===== bench/lzwd_token_checker.sv =====
// Scoreboard for the LZSS window decoder: watches both channels, decodes every
// accepted token into the bytes it must produce, and compares them in order.
// Depends on lzwd_pkg.
module lzwd_token_checker
    import lzwd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_is_match,
    input  t_byte       i_literal_byte,
    input  logic [15:0] i_match_token,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_byte       i_out_byte,
    input  logic        i_out_last,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_byte data;
        logic  last;
    } t_decoded_byte;

    // Private copy of the history window and its write pointer.
    t_byte         history_mem [WIN_DEPTH];
    t_waddr        hist_wr_ptr = '0;
    t_decoded_byte decoded_q [$];
    int            mismatches = 0;

    // Every produced byte goes into the window and becomes an expected output.
    task automatic emit_byte(input t_byte data, input logic last);
        t_decoded_byte entry;
        history_mem[hist_wr_ptr] = data;
        hist_wr_ptr = hist_wr_ptr + 1'b1;
        entry.data = data;
        entry.last = last;
        decoded_q.push_back(entry);
    endtask

    // Expand one token. A distance of a full window wraps to zero in 12 bits,
    // which reads the entry about to be overwritten.
    task automatic decode_token(input logic is_match, input t_byte lit,
                                input logic [15:0] tok);
        int     run_len;
        t_waddr back_dist;
        if (!is_match) begin
            emit_byte(lit, 1'b1);
        end else begin
            run_len   = int'(tok[15:12]) + int'(MIN_MATCH);
            back_dist = t_waddr'(tok[11:0]) + 1'b1;
            for (int i = 0; i < run_len; i++) begin
                emit_byte(history_mem[hist_wr_ptr - back_dist], i == run_len - 1);
            end
        end
    endtask

    // Predict on each input transaction, check each output transaction.
    always @(posedge i_clk) begin
        t_decoded_byte want;
        if (!i_rst_n) begin
            hist_wr_ptr = '0;
            decoded_q.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                decode_token(i_is_match, i_literal_byte, i_match_token);
            end
            if (i_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected byte, expected none, actual %02h last %0b",
                             $time, i_out_byte, i_out_last);
                end else begin
                    want = decoded_q.pop_front();
                    if (want.data !== i_out_byte) begin
                        mismatches++;
                        $display("%0t ns: out_byte mismatch, expected %02h, actual %02h",
                                 $time, want.data, i_out_byte);
                    end
                    if (want.last !== i_out_last) begin
                        mismatches++;
                        $display("%0t ns: last mismatch, expected %0b, actual %0b",
                                 $time, want.last, i_out_last);
                    end
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= decoded_q.size();
    end

endmodule

// ===== bench/lzss_window_decoder_unit_tb.sv =====
// Testbench top for lzss_window_decoder_unit: drives literal and match tokens
// with random idling and back-pressure, and reports the verdict.
// Depends on lzwd_pkg, lzwd_in_if, lzwd_out_if and lzwd_token_checker.
module lzss_window_decoder_unit_tb;
    import lzwd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_TOKENS = 440;
    localparam int CALM_FIRST    = 150;
    localparam int CALM_LAST     = 250;
    localparam int DRAIN_AT      = 300;
    localparam int HOLD_START    = 1500;
    localparam int HOLD_END      = 1900;
    localparam int BUSY_START    = 4000;
    localparam int BUSY_END      = 6000;
    localparam int TAIL_CYCLES   = 24;
    localparam int CYCLE_LIMIT   = 400000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending_bytes;
    int   bytes_written = 0;
    int   cycle_count   = 0;

    lzwd_in_if  in_ch ();
    lzwd_out_if out_ch ();

    lzss_window_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    lzwd_token_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_ch.valid),
        .i_in_ready     (in_ch.ready),
        .i_is_match     (in_ch.is_match),
        .i_literal_byte (in_ch.literal_byte),
        .i_match_token  (in_ch.match_token),
        .i_out_valid    (out_ch.valid),
        .i_out_ready    (out_ch.ready),
        .i_out_byte     (out_ch.out_byte),
        .i_out_last     (out_ch.last),
        .o_fail_count   (fail_count),
        .o_pending      (pending_bytes)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Cycle limit in case the block hangs.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("lzss_window_decoder_unit_tb failed");
        $finish;
    end

    // Offer one token and hold it until the transaction completes, then
    // optionally leave a random gap. The caller is at a rising edge.
    task automatic send_token(input logic is_match, input t_byte lit,
                              input logic [15:0] tok, input bit may_idle);
        in_ch.valid        <= 1'b1;
        in_ch.is_match     <= is_match;
        in_ch.literal_byte <= lit;
        in_ch.match_token  <= tok;
        do @(posedge i_clk); while (!in_ch.ready);
        // Track how far back a match may legally reach.
        bytes_written += is_match ? int'(tok[15:12]) + 3 : 1;
        if (bytes_written > WIN_DEPTH) begin
            bytes_written = WIN_DEPTH;
        end
        if (may_idle && $urandom_range(0, 99) < 30) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Random token that never reaches behind the oldest written byte. Long runs
    // are favored so the write pointer wraps, and short or longest legal distances
    // get extra weight for overlapping copies and the oldest entry.
    task automatic make_token(output logic is_match, output t_byte lit,
                              output logic [15:0] tok);
        int max_dist;
        int reach;
        int pick;
        logic [3:0] len_code;
        lit      = t_byte'($urandom_range(0, 255));
        tok      = 16'($urandom_range(0, 65535));
        is_match = (bytes_written > 0) && ($urandom_range(0, 99) < 80);
        if (is_match) begin
            max_dist = bytes_written;
            pick     = $urandom_range(0, 99);
            if (pick < 25) begin
                reach = $urandom_range(1, (max_dist < 4) ? max_dist : 4);
            end else if (pick < 40) begin
                reach = max_dist;
            end else begin
                reach = $urandom_range(1, max_dist);
            end
            len_code = ($urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom_range(0, 15));
            tok      = {len_code, 12'(reach - 1)};
        end
    endtask

    // Receiver: random stalls, one long hold-off while the sender keeps
    // offering tokens, and a stretch where it never stalls.
    initial begin
        int rx_cycle;
        rx_cycle = 0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_END) begin
                out_ch.ready <= 1'b0;
            end else if (rx_cycle >= BUSY_START && rx_cycle < BUSY_END) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= 30);
            end
            @(posedge i_clk);
            rx_cycle++;
        end
    end

    // Stimulus and verdict.
    initial begin
        logic        is_match;
        t_byte       lit;
        logic [15:0] tok;

        in_ch.valid        <= 1'b0;
        in_ch.is_match     <= 1'b0;
        in_ch.literal_byte <= '0;
        in_ch.match_token  <= '0;
        i_rst_n            <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: literal extremes with the unused token field at both
        // extremes, then shortest and longest runs, overlapping copies and a
        // reach back to the first byte written.
        send_token(1'b0, 8'h00, 16'hFFFF, 1'b1);
        send_token(1'b0, 8'hFF, 16'h0000, 1'b1);
        send_token(1'b0, 8'hA5, 16'h5A5A, 1'b0);
        send_token(1'b0, 8'h5A, 16'hA5A5, 1'b0);
        send_token(1'b1, 8'hFF, 16'h0000, 1'b1);
        send_token(1'b1, 8'h00, 16'hF000, 1'b0);
        send_token(1'b1, 8'h5A, 16'h1001, 1'b1);
        send_token(1'b1, 8'hA5, {4'hF, 12'(bytes_written - 1)}, 1'b0);
        send_token(1'b0, 8'h80, 16'h0000, 1'b1);
        send_token(1'b0, 8'h01, 16'h8000, 1'b0);
        send_token(1'b1, 8'h3C, 16'hD002, 1'b1);
        send_token(1'b1, 8'hC3, 16'h0003, 1'b1);

        // Random tokens, with a calm stretch and one full drain midway.
        for (int n = 0; n < RANDOM_TOKENS; n++) begin
            if (n == DRAIN_AT) begin
                in_ch.valid <= 1'b0;
                do @(posedge i_clk); while (pending_bytes != 0);
            end
            make_token(is_match, lit, tok);
            send_token(is_match, lit, tok, !(n >= CALM_FIRST && n < CALM_LAST));
        end
        in_ch.valid <= 1'b0;

        // Wait for every expected byte, then keep watching for stray bytes.
        do @(posedge i_clk); while (pending_bytes != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_bytes == 0) begin
            $display("lzss_window_decoder_unit_tb passed");
        end else begin
            $display("lzss_window_decoder_unit_tb failed");
        end
        $finish;
    end

endmodule
